### design/cil_pkg.sv
// shared constants, codes and types of the compacting indexed list
package cil_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
	localparam int WORD_W   = 32;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [WORD_W-1:0] READ_ERR_VALUE = '1;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic [6:0]        count;
		logic [1:0]        status;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

### design/compacting_indexed_list.sv
// top level of the compacting indexed list: sequencer, element ram and output register
//
// Request channel: in_valid / in_stall carry op, value and index. op selects
// append of value at the tail, remove at index (later elements move down one
// place) or read at index; an unused op changes nothing and reports ok.
// Result channel: out_valid / out_stall carry read_value, count and status,
// exactly one result beat per request beat, in request order.
// Sequence: append, an unused op, a refused request and removal of the last element
// finish in the request beat; their result is valid the cycle after the request beat.
// A read waits for the registered ram read and then loads the output register.
// A remove at index i moves every later element down one place: the element ram
// moves one word per cycle through its single read and single write port.
// The block holds one request at a time; in_stall is high while a request is
// in progress or while the output register holds a result that is stalled.
// Reset clears the element count and all control state; ram contents are not
// cleared, since positions at or beyond the count are never read.
// A stalled result waits in the output register unchanged until taken.
module compacting_indexed_list (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [31:0] value,
	input  logic [7:0]         index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic [6:0]         count,
	output logic [1:0]         status
);

	cil_pkg::res_t                 res;
	cil_pkg::ram_req_t             ram_req;
	logic [cil_pkg::WORD_W-1:0]    ram_rdata;
	logic                          push;
	logic                          out_free;

	logic                          out_valid_q;
	cil_pkg::res_t                 out_res_q;

	// output stage can take a new beat when empty or draining this cycle
	assign out_free = !out_valid_q || !out_stall;

	cil_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.index     (index),
		.out_free  (out_free),
		.push      (push),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// element store
	cil_ram #(
		.WIDTH (cil_pkg::WORD_W),
		.DEPTH (cil_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// output register: valid flag under reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_res_q.read_value;
	assign count      = out_res_q.count;
	assign status     = out_res_q.status;

endmodule

### design/cil_ram.sv
// generic simple dual-port ram with registered read
module cil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/cil_seq.sv
// request sequencer: decodes requests, drives the element ram, runs the shift loop
module cil_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic signed [31:0]            value,
	input  logic [7:0]                    index,
	input  logic                          out_free,
	output logic                          push,
	output cil_pkg::res_t                 res,
	output cil_pkg::ram_req_t             ram_req,
	input  logic [cil_pkg::WORD_W-1:0]    ram_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RDWAIT,
		S_SHIFT
	} state_t;

	state_t                      state_q;
	logic [cil_pkg::CNT_W-1:0]   fill_q;
	logic [cil_pkg::ADDR_W-1:0]  k_q;

	logic                        acc;
	logic                        in_range;
	logic                        full;
	logic                        shift_needed;
	logic                        last;
	logic [cil_pkg::CMP_W-1:0]   idx_ext;
	logic [cil_pkg::CMP_W-1:0]   fill_ext;
	logic [cil_pkg::CNT_W-1:0]   fill_inc;
	logic [cil_pkg::CNT_W-1:0]   fill_dec;
	logic [cil_pkg::CNT_W-1:0]   k_plus2;
	logic [cil_pkg::ADDR_W-1:0]  idx_a;

	always_comb begin
		in_stall     = (state_q != S_IDLE) || !out_free;
		acc          = in_valid && !in_stall;
		idx_ext      = cil_pkg::CMP_W'(index);
		fill_ext     = cil_pkg::CMP_W'(fill_q);
		in_range     = idx_ext < fill_ext;
		full         = fill_q >= cil_pkg::CNT_W'(cil_pkg::CAPACITY);
		shift_needed = (idx_ext + cil_pkg::CMP_W'(1)) < fill_ext;
		fill_inc     = fill_q + cil_pkg::CNT_W'(1);
		fill_dec     = fill_q - cil_pkg::CNT_W'(1);
		k_plus2      = cil_pkg::CNT_W'(k_q) + cil_pkg::CNT_W'(2);
		last         = k_plus2 >= fill_q;
		idx_a        = index[cil_pkg::ADDR_W-1:0];

		push           = 1'b0;
		res.read_value = '0;
		res.count      = 7'(fill_q);
		res.status     = cil_pkg::ST_OK;
		ram_req.we     = 1'b0;
		ram_req.waddr  = fill_q[cil_pkg::ADDR_W-1:0];
		ram_req.wdata  = value;
		ram_req.re     = 1'b0;
		ram_req.raddr  = idx_a;

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (op)
						cil_pkg::OP_APPEND: begin
							push = 1'b1;
							if (full) begin
								res.status = cil_pkg::ST_FULL;
							end else begin
								ram_req.we = 1'b1;
								res.count  = 7'(fill_inc);
							end
						end
						cil_pkg::OP_REMOVE: begin
							if (!in_range) begin
								push       = 1'b1;
								res.status = cil_pkg::ST_RANGE;
							end else if (shift_needed) begin
								ram_req.re    = 1'b1;
								ram_req.raddr = idx_a + cil_pkg::ADDR_W'(1);
							end else begin
								push      = 1'b1;
								res.count = 7'(fill_dec);
							end
						end
						cil_pkg::OP_READ: begin
							if (!in_range) begin
								push           = 1'b1;
								res.status     = cil_pkg::ST_RANGE;
								res.read_value = cil_pkg::READ_ERR_VALUE;
							end else begin
								ram_req.re = 1'b1;
							end
						end
						default: begin
							push = 1'b1;
						end
					endcase
				end
			end
			S_RDWAIT: begin
				push           = 1'b1;
				res.read_value = ram_rdata;
			end
			S_SHIFT: begin
				// element k+1 is on the read port, store it one place down
				ram_req.we    = 1'b1;
				ram_req.waddr = k_q;
				ram_req.wdata = ram_rdata;
				if (last) begin
					push      = 1'b1;
					res.count = 7'(fill_dec);
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = k_plus2[cil_pkg::ADDR_W-1:0];
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (op)
							cil_pkg::OP_APPEND: begin
								if (!full) begin
									fill_q <= fill_inc;
								end
							end
							cil_pkg::OP_REMOVE: begin
								if (in_range && shift_needed) begin
									state_q <= S_SHIFT;
									k_q     <= idx_a;
								end else if (in_range) begin
									fill_q <= fill_dec;
								end
							end
							cil_pkg::OP_READ: begin
								if (in_range) begin
									state_q <= S_RDWAIT;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RDWAIT: begin
					state_q <= S_IDLE;
				end
				S_SHIFT: begin
					if (last) begin
						fill_q  <= fill_dec;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + cil_pkg::ADDR_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result is only produced when the output stage can take it
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result produced while output stage is occupied");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cil_pkg::CNT_W'(cil_pkg::CAPACITY))
		else $error("fill count beyond capacity");

	// the shift loop never writes at or past the last held element
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (k_plus2 <= fill_q))
		else $error("shift loop ran past the tail");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == cil_pkg::OP_APPEND && !full) |=> (fill_q == $past(fill_inc)))
		else $error("append did not grow the list");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !acc)
		else $error("request taken while a request is in progress");

endmodule

### tb/compacting_indexed_list_tb.sv
// testbench of the compacting indexed list: random and directed requests against a list predictor
`timescale 1ns / 100ps

module compacting_indexed_list_tb;

	// the selector value the block ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_REQS = 2000;
	localparam int CYCLE_LIMIT = 2000000;
	// a remove at the head of a full list moves every later word, so the tail wait grows with CAPACITY
	localparam int TAIL_CYCLES = cil_pkg::CAPACITY + 20;
	// no idling on either side while this many beats are in
	localparam int CALM_FROM   = 900;
	localparam int CALM_TO     = 1200;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] value;
		logic [7:0]  index;
		bit          settle;	// hold off until every result is back
	} list_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = cil_pkg::OP_APPEND;
	logic [31:0] value = '0;
	logic [7:0]  index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_value;
	logic [6:0]  count;
	logic [1:0]  status;

	// stimulus and expectations
	list_req_t       pending_reqs[$];
	cil_pkg::res_t   predicted_results[$];

	// predictor state: the list words and its length
	logic [31:0] list_words[cil_pkg::CAPACITY];
	int          list_len = 0;

	// length the request generator plans with, ahead of the run
	int          plan_len = 0;

	// bookkeeping
	bit          req_taken = 1'b0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          cycles = 0;
	int          mismatches = 0;
	int          n_append = 0;
	int          n_remove = 0;
	int          n_read = 0;
	int          n_unused = 0;
	int          n_refused = 0;
	int          n_dropped = 0;
	int          peak_len = 0;

	wire calm = (beats_in >= CALM_FROM) && (beats_in < CALM_TO);

	compacting_indexed_list dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.value      (value),
		.index      (index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.count      (count),
		.status     (status)
	);

	always #5 clk = ~clk;

	// one request applied to the predicted list; returns the result beat it causes
	function automatic cil_pkg::res_t list_apply(input logic [1:0] req_op,
			input logic [31:0] word, input logic [7:0] pos);
		cil_pkg::res_t r;
		int   k;
		r = '0;
		case (req_op)
			cil_pkg::OP_APPEND: begin
				n_append++;
				if (list_len >= cil_pkg::CAPACITY) begin
					r.status = cil_pkg::ST_FULL;
					n_dropped++;
				end else begin
					list_words[list_len] = word;
					list_len++;
				end
			end
			cil_pkg::OP_REMOVE: begin
				n_remove++;
				if (pos >= list_len) begin
					r.status = cil_pkg::ST_RANGE;
					n_refused++;
				end else begin
					// close the gap: every later word moves down one place
					for (k = pos; k < list_len - 1; k++)
						list_words[k] = list_words[k + 1];
					list_len--;
				end
			end
			cil_pkg::OP_READ: begin
				n_read++;
				if (pos >= list_len) begin
					r.status     = cil_pkg::ST_RANGE;
					r.read_value = cil_pkg::READ_ERR_VALUE;
					n_refused++;
				end else begin
					r.read_value = list_words[pos];
				end
			end
			default: begin
				// unused selector: nothing changes, status ok
				n_unused++;
			end
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		r.count = 7'(list_len);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result beat %0d, %s: got %h, expected %h",
			beats_out, what, got, want);
		mismatches++;
	endtask

	// queue one request and keep the planned length in step
	task automatic add_req(input logic [1:0] req_op, input logic [31:0] word,
			input logic [7:0] pos, input bit settle);
		list_req_t r;
		r.op     = req_op;
		r.value  = word;
		r.index  = pos;
		r.settle = settle;
		pending_reqs.push_back(r);
		if (req_op == cil_pkg::OP_APPEND && plan_len < cil_pkg::CAPACITY)
			plan_len++;
		else if (req_op == cil_pkg::OP_REMOVE && pos < plan_len)
			plan_len--;
	endtask

	// request driver: payload changes at the falling edge only
	always @(negedge clk) begin : request_driver
		list_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !req_taken)) begin
			if (pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_reqs[0].settle && predicted_results.size() != 0) begin
				// wait for the list to drain before this one
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(99) < 34) begin
				in_valid <= 1'b0;
			end else begin
				nxt = pending_reqs.pop_front();
				op       <= nxt.op;
				value    <= nxt.value;
				index    <= nxt.index;
				in_valid <= 1'b1;
			end
		end
	end

	// result sink: random backpressure, none during the calm stretch
	always @(negedge clk) begin : result_sink
		out_stall <= !calm && ($urandom_range(99) < 34);
	end

	// monitor: checks result beats and predicts on every request beat
	always @(posedge clk) begin : monitor
		cil_pkg::res_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycles, predicted_results.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			req_taken = arst_n && in_valid && !in_stall;
			if (arst_n && out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result with nothing expected", read_value, '0);
				end else begin
					want = predicted_results.pop_front();
					if (read_value !== want.read_value)
						report_mismatch("read_value", read_value, want.read_value);
					if (count !== want.count)
						report_mismatch("count", 32'(count), 32'(want.count));
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
				end
				beats_out++;
			end
			// the result of a beat passes the output register before it shows up, so order is safe
			if (req_taken) begin
				predicted_results.push_back(list_apply(op, value, index));
				beats_in++;
			end
		end
	end

	initial begin : stimulus
		int          i;
		int          phase;
		int          roll;
		int          pick;
		logic [1:0]  req_op;
		logic [7:0]  pos;

		// directed: empty list, word extremes, edges of the range, unused selector
		add_req(cil_pkg::OP_READ, '0, 8'd0, 1'b0);
		add_req(cil_pkg::OP_REMOVE, '0, 8'd0, 1'b0);
		add_req(OP_UNUSED, 32'hDEAD_BEEF, 8'd255, 1'b0);
		add_req(cil_pkg::OP_APPEND, 32'h7FFF_FFFF, 8'd0, 1'b0);
		add_req(cil_pkg::OP_APPEND, 32'h8000_0000, 8'd255, 1'b0);
		add_req(cil_pkg::OP_APPEND, 32'hFFFF_FFFF, 8'd0, 1'b0);
		add_req(cil_pkg::OP_APPEND, 32'h0000_0000, 8'd0, 1'b0);
		add_req(cil_pkg::OP_APPEND, 32'h5A5A_A5A5, 8'd0, 1'b0);
		add_req(cil_pkg::OP_READ, '0, 8'd0, 1'b0);
		add_req(cil_pkg::OP_READ, '0, 8'd4, 1'b0);
		add_req(cil_pkg::OP_READ, '0, 8'd5, 1'b0);		// index equal to the count
		add_req(cil_pkg::OP_READ, '1, 8'd255, 1'b0);
		add_req(cil_pkg::OP_REMOVE, '1, 8'd255, 1'b0);
		add_req(OP_UNUSED, '1, 8'd0, 1'b0);
		add_req(cil_pkg::OP_REMOVE, '0, 8'd1, 1'b0);	// middle: later words move down
		add_req(cil_pkg::OP_READ, '0, 8'd1, 1'b0);
		add_req(cil_pkg::OP_REMOVE, '0, 8'd3, 1'b0);	// last word
		add_req(cil_pkg::OP_REMOVE, '0, 8'd0, 1'b0);	// head
		add_req(cil_pkg::OP_READ, '0, 8'd0, 1'b0);
		add_req(cil_pkg::OP_READ, '0, 8'd1, 1'b1);
		add_req(cil_pkg::OP_READ, '0, 8'd2, 1'b0);

		// random: phases of growth, mixed traffic and shrinking so the list
		// swings between empty and full many times
		for (i = 0; i < RANDOM_REQS; i++) begin
			phase = (i / 100) % 4;
			roll  = $urandom_range(99);
			if (phase == 0 || phase == 3)
				req_op = (roll < 75) ? cil_pkg::OP_APPEND :
					(roll < 85) ? cil_pkg::OP_REMOVE :
					(roll < 97) ? cil_pkg::OP_READ : OP_UNUSED;
			else if (phase == 1)
				req_op = (roll < 40) ? cil_pkg::OP_APPEND :
					(roll < 70) ? cil_pkg::OP_REMOVE :
					(roll < 95) ? cil_pkg::OP_READ : OP_UNUSED;
			else
				req_op = (roll < 15) ? cil_pkg::OP_APPEND :
					(roll < 70) ? cil_pkg::OP_REMOVE :
					(roll < 96) ? cil_pkg::OP_READ : OP_UNUSED;
			pick = $urandom_range(99);
			if (plan_len > 0 && pick < 75)
				pos = 8'($urandom_range(plan_len - 1, 0));
			else if (pick < 85)
				pos = 8'(plan_len);
			else
				pos = 8'($urandom_range(255, 0));
			add_req(req_op, $urandom, pos, (i % 400) == 399);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(negedge clk);
		while (predicted_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d requests, %0d results: %0d appends (%0d full), %0d removes, %0d reads",
			beats_in, beats_out, n_append, n_dropped, n_remove, n_read);
		$display("%0d unused ops, %0d out of range, peak %0d of %0d, %0d mismatches",
			n_unused, n_refused, peak_len, cil_pkg::CAPACITY, mismatches);
		if (mismatches == 0 && predicted_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### compacting_indexed_list.f
design/cil_pkg.sv
design/cil_ram.sv
design/cil_seq.sv
design/compacting_indexed_list.sv
tb/compacting_indexed_list_tb.sv
